/* hw/rtl/sab_pkg.sv */
// Shared types and constants of the slotted ALOHA backoff transmitter.
// Used by sab_step and by the top level slotted_aloha_backoff_mac.
package sab_pkg;

	localparam int RAND_BITS       = 16;
	localparam int MAX_CHANNELS    = 16;
	localparam int QUEUE_DEPTH     = 1024;
	localparam int MAX_BACKOFF_EXP = 10;

	localparam int KIND_W  = 2;
	localparam int SEND_W  = 8;
	localparam int CNT_W   = 11;
	localparam int CH_W    = 4;
	localparam int COLL_W  = 4;
	localparam int BO_W    = 10;
	localparam int NCH_W   = 5;
	localparam int THR_W   = 17;
	localparam int MUL_B_W = 10;
	localparam int PROD_W  = RAND_BITS + MUL_B_W;

	localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

	localparam logic CFG_NUM_CHANNELS = 1'b0;
	localparam logic CFG_THRESHOLD    = 1'b1;

	localparam logic [NCH_W-1:0] RESET_NUM_CHANNELS = 5'd4;
	localparam logic [THR_W-1:0] RESET_THRESHOLD    = 17'd65536;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [RAND_BITS-1:0] rand_channel;
		logic [RAND_BITS-1:0] rand_attempt;
		logic [RAND_BITS-1:0] rand_backoff;
		logic [SEND_W-1:0]    senders_on_channel;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  queued_count;
		logic [CH_W-1:0]   chosen_channel;
		logic              channel_chosen;
		logic [COLL_W-1:0] head_collisions;
		logic [BO_W-1:0]   backoff_counter;
		logic              attempt_pending;
	} state_t;

	typedef struct packed {
		logic [BO_W-1:0]   backoff_left;
		logic [COLL_W-1:0] collision_count;
		logic [CNT_W-1:0]  queue_length;
		logic              dropped;
		logic              collided;
		logic              delivered;
		logic              channel_valid;
		logic [CH_W-1:0]   channel;
		logic              attempted;
	} result_t;

	typedef struct packed {
		logic [NCH_W-1:0] num_channels;
		logic [THR_W-1:0] transmit_threshold;
	} cfg_t;

endpackage

/* hw/rtl/sab_step.sv */
// Next-state and result logic for one item of the backoff transmitter.
// Depends on sab_pkg; one shared multiplier scales the channel or backoff draw.
module sab_step (
	input  sab_pkg::cfg_t    cfg,
	input  sab_pkg::item_t   item,
	input  sab_pkg::state_t  state,
	output sab_pkg::state_t  state_next,
	output sab_pkg::result_t result
);

	logic [sab_pkg::NCH_W-1:0]     chan_n;
	logic [sab_pkg::COLL_W-1:0]    exp_n;
	logic [sab_pkg::BO_W:0]        win_wide;
	logic [sab_pkg::MUL_B_W-1:0]   mul_b;
	logic [sab_pkg::RAND_BITS-1:0] mul_a;
	logic [sab_pkg::PROD_W-1:0]    prod;
	logic                          attempt_ok;

	always_comb begin
		if (cfg.num_channels == '0) begin
			chan_n = sab_pkg::NCH_W'(1);
		end else if (cfg.num_channels > sab_pkg::NCH_W'(sab_pkg::MAX_CHANNELS)) begin
			chan_n = sab_pkg::NCH_W'(sab_pkg::MAX_CHANNELS);
		end else begin
			chan_n = cfg.num_channels;
		end
	end

	always_comb begin
		if (state.head_collisions >= sab_pkg::COLL_W'(sab_pkg::MAX_BACKOFF_EXP)) begin
			exp_n = sab_pkg::COLL_W'(sab_pkg::MAX_BACKOFF_EXP);
		end else begin
			exp_n = state.head_collisions + sab_pkg::COLL_W'(1);
		end
	end

	assign win_wide = ((sab_pkg::BO_W + 1)'(1) << exp_n) - (sab_pkg::BO_W + 1)'(1);

	always_comb begin
		if (item.kind == sab_pkg::KIND_TICK) begin
			mul_a = item.rand_channel;
			mul_b = sab_pkg::MUL_B_W'(chan_n);
		end else begin
			mul_a = item.rand_backoff;
			mul_b = win_wide[sab_pkg::MUL_B_W-1:0];
		end
	end

	assign prod = sab_pkg::PROD_W'(mul_a) * sab_pkg::PROD_W'(mul_b);
	assign attempt_ok = {1'b0, item.rand_attempt} < cfg.transmit_threshold;

	always_comb begin
		state_next       = state;
		result           = '0;
		unique case (item.kind)
			sab_pkg::KIND_ARRIVAL: begin
				if (state.queued_count < sab_pkg::CNT_W'(sab_pkg::QUEUE_DEPTH)) begin
					state_next.queued_count = state.queued_count + sab_pkg::CNT_W'(1);
				end else begin
					result.dropped = 1'b1;
				end
			end
			sab_pkg::KIND_TICK: begin
				if (state.queued_count != '0) begin
					if (!state.channel_chosen) begin
						state_next.chosen_channel = prod[sab_pkg::RAND_BITS +: sab_pkg::CH_W];
						state_next.channel_chosen = 1'b1;
						result.attempted          = attempt_ok;
					end else if (state.backoff_counter != '0) begin
						state_next.backoff_counter = state.backoff_counter - sab_pkg::BO_W'(1);
					end else begin
						result.attempted = attempt_ok;
					end
					if (result.attempted) begin
						state_next.attempt_pending = 1'b1;
					end
				end
			end
			sab_pkg::KIND_CHECK: begin
				if (state.attempt_pending) begin
					state_next.attempt_pending = 1'b0;
					if (item.senders_on_channel > sab_pkg::SEND_W'(1)) begin
						state_next.backoff_counter =
							prod[sab_pkg::RAND_BITS +: sab_pkg::BO_W] + sab_pkg::BO_W'(1);
						if (state.head_collisions <
							sab_pkg::COLL_W'(sab_pkg::MAX_BACKOFF_EXP)) begin
							state_next.head_collisions =
								state.head_collisions + sab_pkg::COLL_W'(1);
						end
						result.collided = 1'b1;
					end else begin
						if (state.queued_count != '0) begin
							state_next.queued_count = state.queued_count - sab_pkg::CNT_W'(1);
						end
						state_next.channel_chosen  = 1'b0;
						state_next.chosen_channel  = '0;
						state_next.head_collisions = '0;
						state_next.backoff_counter = '0;
						result.delivered           = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		result.channel         = state_next.chosen_channel;
		result.channel_valid   = state_next.channel_chosen;
		result.queue_length    = state_next.queued_count;
		result.collision_count = state_next.head_collisions;
		result.backoff_left    = state_next.backoff_counter;
	end

endmodule

/* hw/rtl/slotted_aloha_backoff_mac.sv */
// Slotted ALOHA transmitter with binary exponential backoff, top level.
// The result of an item passes the input register and then the result register before it is offered;
// while a result waits on m_tready, the item behind it is held in the input register.
// Throughput: one item per cycle unless m_tready holds a result; the input register then takes one more.
// The state update for an item is one pass through sab_step between those two registers.
// Reset clears the queue and head packet state; num_channels resets to 4, threshold to 65536.
// Depends on sab_pkg and sab_step.
module slotted_aloha_backoff_mac (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// rand_channel [15:0], rand_attempt [31:16], rand_backoff [47:32],
	// senders_on_channel [55:48].
	input  logic [55:0] s_tdata,
	// kind [1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// attempted [0], channel [4:1], channel_valid [5], delivered [6], collided [7],
	// dropped [8], queue_length [19:9], collision_count [23:20], backoff_left [33:24],
	// zero [39:34].
	output logic [39:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	sab_pkg::cfg_t    cfg_q;
	sab_pkg::state_t  state_q;
	sab_pkg::state_t  state_next;
	sab_pkg::item_t   item_s1;
	sab_pkg::result_t result;
	sab_pkg::result_t result_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_channels       <= sab_pkg::RESET_NUM_CHANNELS;
			cfg_q.transmit_threshold <= sab_pkg::RESET_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sab_pkg::CFG_NUM_CHANNELS: cfg_q.num_channels <= cfg_data[sab_pkg::NCH_W-1:0];
				sab_pkg::CFG_THRESHOLD:    cfg_q.transmit_threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind               <= s_tuser;
			item_s1.rand_channel       <= s_tdata[15:0];
			item_s1.rand_attempt       <= s_tdata[31:16];
			item_s1.rand_backoff       <= s_tdata[47:32];
			item_s1.senders_on_channel <= s_tdata[55:48];
		end
	end

	sab_step u_step (
		.cfg        (cfg_q),
		.item       (item_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, result_q};

	a_drain_never_blocks_input: assert property (
		@(posedge clk) disable iff (!arst_n) m_tready |-> s_tready
	) else $error("input stalled while the result side drains");

	a_flags_exclusive: assert property (
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_q.delivered && result_q.collided)
	) else $error("result reports delivery and collision together");

	a_collision_sets_backoff: assert property (
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.collided) |->
			(result_q.backoff_left != '0 && result_q.channel_valid)
	) else $error("collision result without backoff or channel");

	a_delivery_clears_head: assert property (
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.delivered) |->
			(!result_q.channel_valid && result_q.backoff_left == '0 &&
			 result_q.collision_count == '0)
	) else $error("delivery left head packet state behind");

	a_attempt_has_channel: assert property (
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.attempted) |-> (result_q.channel_valid && state_q.attempt_pending)
	) else $error("attempt reported without a chosen channel or pending mark");

	a_queue_bounded: assert property (
		@(posedge clk) disable iff (!arst_n)
		state_q.queued_count <= sab_pkg::CNT_W'(sab_pkg::QUEUE_DEPTH)
	) else $error("queue count beyond its depth");

endmodule
